// ===== rtl/core/tfa_pkg.sv =====
`timescale 1ns / 1ps

package tfa_pkg;

   // datapath sizing
   localparam int PHASE_BITS   = 32;
   localparam int SAMPLE_BITS  = 16;
   localparam int COUNT_BITS   = 16;

   // phase bits below the kept precision are cleared
   localparam int PHASE_DROP = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
   localparam logic [31:0] PHASE_MASK = ~((32'(1) << PHASE_DROP) - 32'(1));

   // cordic
   localparam int CORDIC_STEPS = 24;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int ROT_W        = 34;
   localparam int ANG_W        = 33;
   localparam logic signed [ROT_W-1:0] X_INIT = ROT_W'(32'h26DD3B6A);

   // front to back queue
   localparam int QUEUE_DEPTH = 2;

   // register file
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_WAVEFORM           = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_FREQ_WORD   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVIATION_WORD     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_INDEX        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES_PER_SYMBOL = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_MODE           = 3'd7;

   // waveform codes
   localparam logic [1:0] WAVE_TONE = 2'd0;
   localparam logic [1:0] WAVE_FSK  = 2'd1;
   localparam logic [1:0] WAVE_ASK  = 2'd2;

   typedef struct packed {
      logic [1:0]         waveform;
      logic [14:0]        amplitude;
      logic [31:0]        center_freq_word;
      logic [30:0]        deviation_word;
      logic signed [15:0] start_index;
      logic [16:0]        sample_count;
      logic [15:0]        samples_per_symbol;
      logic               bit_mode;
   } cfg_type;

   // one sample job handed from front to back
   typedef struct packed {
      logic [31:0] phase;
      logic        info_bit;
      logic        last_sample;
      logic        mute;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ROTATE,
      BK_FOLD,
      BK_MULT,
      BK_DONE
   } back_state_type;

   // atan(2^-k) in units of 2^-32 turn
   function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] k);
      logic [31:0] a;
      case (k)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         default: a = 32'h0;
      endcase
      return $signed(ANG_W'(a));
   endfunction

endpackage

// ===== rtl/core/tfa_if.sv =====
`timescale 1ns / 1ps

interface tfa_req_if;
   logic valid;
   logic ready;
   logic random_bit;

   modport source (output valid, output random_bit, input ready);
   modport sink (input valid, input random_bit, output ready);
endinterface

interface tfa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] i_value;
   logic signed [15:0] q_value;
   logic               info_bit;
   logic               last_sample;

   modport source (output valid, output i_value, output q_value, output info_bit,
                   output last_sample, input ready);
   modport sink (input valid, input i_value, input q_value, input info_bit,
                 input last_sample, output ready);
endinterface

interface tfa_csr_if import tfa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/tfa_front.sv =====
`timescale 1ns / 1ps

module tfa_front import tfa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   tfa_req_if.sink req_bus,
   input  cfg_type cfg,
   input  logic    queue_full,
   output logic    push,
   output job_type push_job
);

   localparam int CMP_W = (COUNT_BITS + 1 > 17) ? COUNT_BITS + 1 : 17;
   localparam int IDX_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;
   localparam logic [CMP_W-1:0] FRAME_MAX = CMP_W'(1) << COUNT_BITS;

   logic [COUNT_BITS-1:0] sample_counter_ff, sample_counter_in;
   logic [COUNT_BITS-1:0] symbol_counter_ff, symbol_counter_in;
   logic                  current_bit_ff, current_bit_in;

   logic [CMP_W-1:0]        frame_len, last_pos;
   logic [COUNT_BITS-1:0]   pos_step;
   logic                    boundary, last_now;
   logic signed [IDX_W-1:0] sample_index;
   logic [31:0]             freq;
   logic signed [IDX_W+32:0] product;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   // clamp frame length to 1 .. 2^COUNT_BITS
   always_comb begin
      frame_len = CMP_W'(cfg.sample_count);
      if (cfg.sample_count == '0) begin
         frame_len = CMP_W'(1);
      end else if (frame_len > FRAME_MAX) begin
         frame_len = FRAME_MAX;
      end
      last_pos = frame_len - CMP_W'(1);
   end

   // information bit and symbol position
   always_comb begin
      pos_step = symbol_counter_ff + COUNT_BITS'(1);
      boundary = (cfg.samples_per_symbol != '0) &&
                 (CMP_W'(pos_step) == CMP_W'(cfg.samples_per_symbol));
      if (sample_counter_ff == '0) begin
         current_bit_in    = 1'b0;
         symbol_counter_in = '0;
      end else if (boundary) begin
         current_bit_in    = cfg.bit_mode ? req_bus.random_bit : !current_bit_ff;
         symbol_counter_in = '0;
      end else begin
         current_bit_in    = current_bit_ff;
         symbol_counter_in = pos_step;
      end
      last_now          = (CMP_W'(sample_counter_ff) == last_pos);
      sample_counter_in = last_now ? '0 : sample_counter_ff + COUNT_BITS'(1);
   end

   // phase = frequency times sample index, modulo one turn
   always_comb begin
      case (cfg.waveform)
         WAVE_FSK: begin
            freq = current_bit_in ? cfg.center_freq_word + {1'b0, cfg.deviation_word}
                                  : cfg.center_freq_word - {1'b0, cfg.deviation_word};
         end
         default: begin
            freq = cfg.center_freq_word;
         end
      endcase
      sample_index = IDX_W'(cfg.start_index) + $signed(IDX_W'(sample_counter_ff));
      product      = $signed({1'b0, freq}) * sample_index;

      push_job.phase       = product[31:0] & PHASE_MASK;
      push_job.info_bit    = current_bit_in;
      push_job.last_sample = last_now;
      push_job.mute        = (cfg.waveform == WAVE_ASK) && !current_bit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_counter_ff <= '0;
         symbol_counter_ff <= '0;
         current_bit_ff    <= 1'b0;
      end else if (push) begin
         sample_counter_ff <= sample_counter_in;
         symbol_counter_ff <= symbol_counter_in;
         current_bit_ff    <= current_bit_in;
      end
   end

endmodule

// ===== rtl/core/tfa_queue.sv =====
`timescale 1ns / 1ps

module tfa_queue import tfa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full    = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");

   assert property (@(posedge clock) disable iff (reset)
                    (wr_ptr_ff == rd_ptr_ff) |-> (empty || full))
      else $error("queue pointers disagree with fill count");

endmodule

// ===== rtl/core/tfa_back.sv =====
`timescale 1ns / 1ps

module tfa_back import tfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  job_type      pop_job,
   input  logic         queue_empty,
   output logic         pop,
   input  logic [14:0]  amplitude,
   tfa_rsp_if.source    rsp_bus
);

   localparam logic signed [31:0] SAMPLE_MAX = 32'((64'(1) << (SAMPLE_BITS - 1)) - 64'(1));
   localparam logic signed [31:0] SAMPLE_MIN = -SAMPLE_MAX - 32'sd1;

   back_state_type state_ff, state_in;

   logic [STEP_W-1:0]        step_ff;
   logic signed [ROT_W-1:0]  x_ff, y_ff, x_next, y_next;
   logic signed [ANG_W-1:0]  z_ff, z_next;
   logic [1:0]               quad_ff;
   logic                     bit_ff, last_ff, mute_ff;
   logic signed [15:0]       cq_ff, sq_ff, cq_in, sq_in, c_q15, s_q15;
   logic signed [31:0]       pi_ff, pq_ff;
   logic signed [31:0]       i_round, q_round;

   logic                     rsp_valid_ff;
   logic signed [15:0]       i_out_ff, q_out_ff;
   logic                     info_out_ff, last_out_ff;

   logic out_free, load_out;

   function automatic logic signed [15:0] to_q15(input logic signed [ROT_W-1:0] v);
      logic signed [ROT_W-1:0] r;
      r = (v + ROT_W'(16384)) >>> 15;
      if (r > ROT_W'(32767)) begin
         r = ROT_W'(32767);
      end else if (r < -ROT_W'(32767)) begin
         r = -ROT_W'(32767);
      end
      return r[15:0];
   endfunction

   function automatic logic signed [31:0] scale_round(input logic signed [31:0] p);
      logic signed [31:0] r;
      r = (p + 32'sd16384) >>> 15;
      if (r > SAMPLE_MAX) begin
         r = SAMPLE_MAX;
      end else if (r < SAMPLE_MIN) begin
         r = SAMPLE_MIN;
      end
      return r;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) state_in = BK_ROTATE;
         end
         BK_ROTATE: begin
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = BK_FOLD;
         end
         BK_FOLD: state_in = BK_MULT;
         BK_MULT: state_in = BK_DONE;
         BK_DONE: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_IDLE: pop      = !queue_empty;
         BK_DONE: load_out = out_free;
         default: ;
      endcase
   end

   // one cordic micro-rotation
   always_comb begin
      if (!z_ff[ANG_W-1]) begin
         x_next = x_ff - (y_ff >>> step_ff);
         y_next = y_ff + (x_ff >>> step_ff);
         z_next = z_ff - atan_step(step_ff);
      end else begin
         x_next = x_ff + (y_ff >>> step_ff);
         y_next = y_ff - (x_ff >>> step_ff);
         z_next = z_ff + atan_step(step_ff);
      end
   end

   // quadrant fold, ask muting and rounding of the scaled products
   always_comb begin
      c_q15 = to_q15(x_ff);
      s_q15 = to_q15(y_ff);
      case (quad_ff)
         2'd0: begin cq_in = c_q15;  sq_in = s_q15;  end
         2'd1: begin cq_in = -s_q15; sq_in = c_q15;  end
         2'd2: begin cq_in = -c_q15; sq_in = -s_q15; end
         default: begin cq_in = s_q15; sq_in = -c_q15; end
      endcase
      if (mute_ff) begin
         cq_in = '0;
         sq_in = '0;
      end
      i_round = scale_round(pi_ff);
      q_round = scale_round(pq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (pop) begin
         step_ff <= '0;
      end else if (state_ff == BK_ROTATE) begin
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               x_ff    <= X_INIT;
               y_ff    <= '0;
               z_ff    <= $signed(ANG_W'(pop_job.phase[29:0]));
               quad_ff <= pop_job.phase[31:30];
               bit_ff  <= pop_job.info_bit;
               last_ff <= pop_job.last_sample;
               mute_ff <= pop_job.mute;
            end
         end
         BK_ROTATE: begin
            x_ff <= x_next;
            y_ff <= y_next;
            z_ff <= z_next;
         end
         BK_FOLD: begin
            cq_ff <= cq_in;
            sq_ff <= sq_in;
         end
         BK_MULT: begin
            pi_ff <= $signed({1'b0, amplitude}) * cq_ff;
            pq_ff <= $signed({1'b0, amplitude}) * sq_ff;
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         i_out_ff    <= i_round[15:0];
         q_out_ff    <= q_round[15:0];
         info_out_ff <= bit_ff;
         last_out_ff <= last_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.i_value     = i_out_ff;
   assign rsp_bus.q_value     = q_out_ff;
   assign rsp_bus.info_bit    = info_out_ff;
   assign rsp_bus.last_sample = last_out_ff;

   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == BK_ROTATE) |-> (step_ff < STEP_W'(CORDIC_STEPS)))
      else $error("cordic step past table end");

   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == BK_FOLD) |-> ($past(step_ff) == STEP_W'(CORDIC_STEPS - 1)))
      else $error("fold entered before all rotations");

   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_valid_ff) |-> ($past(state_ff) == BK_DONE))
      else $error("result shown without a finished sample");

endmodule

// ===== rtl/core/tone_fsk_ask_modulator.sv =====
`timescale 1ns / 1ps

// channel  | dir | beat carries                               | handshake
// ---------+-----+--------------------------------------------+------------
// req_bus  | in  | random_bit                                 | valid/ready
// rsp_bus  | out | i_value, q_value, info_bit, last_sample    | valid/ready
// csr_bus  | in  | index (register number), data              | valid/ready
//
// the back end takes one sample at a time: pop, 24 cordic steps on
// one shared rotator, then fold, multiply and output load
// reset is synchronous and active high; configuration registers return to their defaults
// a stalled response waits in the output register while the next one rotates
// req_ready drops only when the two-entry queue is full

module tone_fsk_ask_modulator import tfa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tfa_req_if.sink    req_bus,
   tfa_rsp_if.source  rsp_bus,
   tfa_csr_if.sink    csr_bus
);

   cfg_type cfg_ff;

   // front to queue
   logic    push;
   job_type push_job;
   logic    queue_full;

   // queue to back
   logic    pop;
   job_type pop_job;
   logic    queue_empty;

   // register writes are always taken
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.waveform           <= WAVE_TONE;
         cfg_ff.amplitude          <= 15'd16384;
         cfg_ff.center_freq_word   <= '0;
         cfg_ff.deviation_word     <= '0;
         cfg_ff.start_index        <= '0;
         cfg_ff.sample_count       <= 17'd1024;
         cfg_ff.samples_per_symbol <= 16'd8;
         cfg_ff.bit_mode           <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_WAVEFORM:           cfg_ff.waveform           <= csr_bus.data[1:0];
            CSR_AMPLITUDE:          cfg_ff.amplitude          <= csr_bus.data[14:0];
            CSR_CENTER_FREQ_WORD:   cfg_ff.center_freq_word   <= csr_bus.data[31:0];
            CSR_DEVIATION_WORD:     cfg_ff.deviation_word     <= csr_bus.data[30:0];
            CSR_START_INDEX:        cfg_ff.start_index        <= $signed(csr_bus.data[15:0]);
            CSR_SAMPLE_COUNT:       cfg_ff.sample_count       <= csr_bus.data[16:0];
            CSR_SAMPLES_PER_SYMBOL: cfg_ff.samples_per_symbol <= csr_bus.data[15:0];
            CSR_BIT_MODE:           cfg_ff.bit_mode           <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   // front: frame and symbol counting, bit selection, phase multiply
   tfa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // short queue of phase jobs so either side can stall on its own
   tfa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   // back: iterative cordic, amplitude scaling, output register
   tfa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_job     (pop_job),
      .queue_empty (queue_empty),
      .pop         (pop),
      .amplitude   (cfg_ff.amplitude),
      .rsp_bus     (rsp_bus)
   );

endmodule
